// File: rtl/xtea_pkg.sv
// ----------------------------------------------------------------------------
// XTEA package
// Shared types, constants and the round mixing function for the XTEA
// block cipher pipeline.
// ----------------------------------------------------------------------------
package xtea_pkg;

    // Round sum step
    localparam logic [31:0] DELTA = 32'h9E37_79B9;

    // Default number of Feistel rounds
    localparam int ROUNDS_DEFAULT = 32;

    // Key storage
    localparam int KEY_WORDS = 4;
    localparam int KEY_IDX_W = $clog2(KEY_WORDS);

    // Configuration port geometry
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = KEY_IDX_W + 2;

    typedef logic [KEY_WORDS-1:0][31:0] t_key_set;

    // One block in flight through the round stages
    typedef struct packed {
        logic        func;
        logic [31:0] v0;
        logic [31:0] v1;
    } t_blk;

    // One result block
    typedef struct packed {
        logic [31:0] v0;
        logic [31:0] v1;
    } t_res;

    // Shift/xor/add mixing of one half
    function automatic logic [31:0] mix(input logic [31:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

endpackage

// File: rtl/xtea_block_cipher_unit.sv
// Path: an accepted request passes one registered stage per half round,
// then the output register, before it shows on o_valid.
// Throughput: one block per cycle while the skid entry is empty.
// Reset (i_rst_n low, synchronous): clears all stage valids, the output
// register and skid entry valid flags, and the four key words.
// ----------------------------------------------------------------------------
// XTEA block cipher unit
// Fully unrolled XTEA encipher/decipher pipeline with an APB key port.
// ----------------------------------------------------------------------------
module xtea_block_cipher_unit #(
    parameter int ROUNDS = xtea_pkg::ROUNDS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // Key configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [xtea_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [xtea_pkg::APB_DATA_W-1:0] pwdata,
    output logic [xtea_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,

    // Block request channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_func,
    input  logic [31:0]                     i_half_first,
    input  logic [31:0]                     i_half_second,

    // Result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [31:0]                     o_out_first,
    output logic [31:0]                     o_out_second
);

    localparam int STAGES = 2 * ROUNDS;

    xtea_pkg::t_key_set              r_key;
    logic [xtea_pkg::KEY_IDX_W-1:0]  cfg_idx;
    logic                            cfg_wr;

    logic                            en;
    logic                            skid_full;
    logic                            push;
    logic                            vld [0:STAGES];
    xtea_pkg::t_blk                  blk [0:STAGES];
    xtea_pkg::t_res                  res_in;
    xtea_pkg::t_res                  res_out;

    // Key register writes and reads
    assign cfg_idx = paddr[xtea_pkg::APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = r_key[cfg_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (cfg_wr) begin
            r_key[cfg_idx] <= pwdata;
        end
    end

    // Pipeline advances unless the skid entry is occupied
    assign en      = !skid_full;
    assign o_stall = skid_full;

    assign vld[0]      = i_valid;
    assign blk[0].func = i_func;
    assign blk[0].v0   = i_half_first;
    assign blk[0].v1   = i_half_second;

    // Half round stages
    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        xtea_half_round #(
            .ROUNDS (ROUNDS),
            .STAGE  (s)
        ) u_half_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (vld[s]),
            .i_blk   (blk[s]),
            .i_keys  (r_key),
            .o_valid (vld[s+1]),
            .o_blk   (blk[s+1])
        );
    end

    // Hand finished blocks to the output buffer
    assign push      = en && vld[STAGES];
    assign res_in.v0 = blk[STAGES].v0;
    assign res_in.v1 = blk[STAGES].v1;

    xtea_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res_in),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (res_out),
        .o_full  (skid_full)
    );

    assign o_out_first  = res_out.v0;
    assign o_out_second = res_out.v1;

`ifndef ASSERT_OFF
    // Skid entry is only used behind a held output
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        skid_full |-> o_valid)
        else $error("skid entry occupied with empty output register");

    // A finished block arriving at a stalled output lands in the skid entry
    a_skid_catch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall && push) |=> skid_full)
        else $error("finished block not captured while output stalled");

    // Last stage holds its block while the pipeline is frozen
    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        skid_full |=> ($stable(blk[STAGES]) && $stable(vld[STAGES])))
        else $error("last stage changed while pipeline stalled");
`endif

endmodule

// File: rtl/xtea_half_round.sv
// ----------------------------------------------------------------------------
// XTEA half round stage
// One registered half of a Feistel round. The round sum and key word index
// are fixed per stage and per operation, so only a two-way select on func
// remains in the datapath.
// ----------------------------------------------------------------------------
module xtea_half_round #(
    parameter int ROUNDS = xtea_pkg::ROUNDS_DEFAULT,
    parameter int STAGE  = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  xtea_pkg::t_blk    i_blk,
    input  xtea_pkg::t_key_set i_keys,
    output logic              o_valid,
    output xtea_pkg::t_blk    o_blk
);

    localparam int RND  = STAGE / 2;
    localparam int HALF = STAGE % 2;

    // Round sum seen by this half for each direction
    localparam logic [31:0] ENC_SUM = 32'((RND + HALF) * xtea_pkg::DELTA);
    localparam logic [31:0] DEC_SUM = 32'((ROUNDS - RND - HALF) * xtea_pkg::DELTA);

    localparam logic HALF_BIT = (HALF != 0);

    logic                            upd_v0;
    logic [31:0]                     sum;
    logic [xtea_pkg::KEY_IDX_W-1:0]  kidx;
    logic [31:0]                     src;
    logic [31:0]                     dst;
    logic [31:0]                     tweak;
    logic [31:0]                     n_dst;
    xtea_pkg::t_blk                  n_blk;
    xtea_pkg::t_blk                  r_blk;
    logic                            r_valid;

    // Pick which half is updated and the key word for this step
    always_comb begin
        upd_v0 = (i_blk.func == HALF_BIT);
        sum    = i_blk.func ? DEC_SUM : ENC_SUM;
        kidx   = upd_v0 ? sum[1:0] : sum[12:11];
        src    = upd_v0 ? i_blk.v1 : i_blk.v0;
        dst    = upd_v0 ? i_blk.v0 : i_blk.v1;
    end

    // Mix and fold into the target half
    always_comb begin
        tweak = xtea_pkg::mix(src) ^ (sum + i_keys[kidx]);
        n_dst = i_blk.func ? (dst - tweak) : (dst + tweak);
        n_blk = i_blk;
        if (upd_v0) begin
            n_blk.v0 = n_dst;
        end else begin
            n_blk.v1 = n_dst;
        end
    end

    // Advance valid with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Hold payload on stall
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_blk <= n_blk;
        end
    end

    assign o_valid = r_valid;
    assign o_blk   = r_blk;

endmodule

// File: rtl/xtea_out_buf.sv
// ----------------------------------------------------------------------------
// XTEA output buffer
// Output register plus one skid entry. The skid flag is registered and
// stalls the round pipeline, so the input side never waits on the output
// stall combinationally.
// ----------------------------------------------------------------------------
module xtea_out_buf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  xtea_pkg::t_res i_res,
    input  logic           i_stall,
    output logic           o_valid,
    output xtea_pkg::t_res o_res,
    output logic           o_full
);

    logic           r_out_valid;
    logic           r_skid_valid;
    xtea_pkg::t_res r_out;
    xtea_pkg::t_res r_skid;

    logic           n_out_valid;
    logic           n_skid_valid;
    xtea_pkg::t_res n_out;
    xtea_pkg::t_res n_skid;
    logic           take;
    logic           load;

    // Refill output from skid first, else from the pipeline
    always_comb begin
        take         = r_out_valid && !i_stall;
        load         = !r_out_valid || take;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (load) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid  = i_push;
                n_out        = i_res;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_full  = r_skid_valid;

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// XTEA block cipher unit testbench
// Loads keys over the APB port and reads them back. Sends encipher and
// decipher requests, first directed corner blocks, then random traffic under
// several keys and idle patterns. Every result block is checked against a
// cycle-free software cipher kept in step with the programmed key.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ROUNDS       = xtea_pkg::ROUNDS_DEFAULT;
    localparam int REG_STRIDE     = 4;
    localparam int HOLD_CYCLES    = 2 * N_ROUNDS + 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int BLOCKS_PER_KEY = 110;
    localparam int KEYS_PER_PHASE = 5;

    localparam logic FUNC_ENC = 1'b0;
    localparam logic FUNC_DEC = 1'b1;

    typedef logic [xtea_pkg::APB_ADDR_W-1:0] t_paddr;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            psel          = 1'b0;
    logic                            penable       = 1'b0;
    logic                            pwrite        = 1'b0;
    t_paddr                          paddr         = '0;
    logic [xtea_pkg::APB_DATA_W-1:0] pwdata        = '0;
    logic [xtea_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            i_valid       = 1'b0;
    logic                            o_stall;
    logic                            i_func        = 1'b0;
    logic [31:0]                     i_half_first  = '0;
    logic [31:0]                     i_half_second = '0;
    logic                            o_valid;
    logic                            i_stall       = 1'b0;
    logic [31:0]                     o_out_first;
    logic [31:0]                     o_out_second;

    xtea_pkg::t_key_set key_model = '0;
    xtea_pkg::t_res     pending_blocks[$];
    int                 fail_count     = 0;
    int                 quiet_cycles   = 0;
    int                 send_gap_pct   = 0;
    int                 recv_stall_pct = 0;

    xtea_block_cipher_unit #(
        .ROUNDS(N_ROUNDS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_half_first (i_half_first),
        .i_half_second(i_half_second),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_first  (o_out_first),
        .o_out_second (o_out_second)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Shift/xor/add mixing of one half
    function automatic logic [31:0] feistel_mix(input logic [31:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    // Encipher or decipher one block under the given key
    function automatic xtea_pkg::t_res cipher_block(input logic func,
                                                    input logic [31:0] first,
                                                    input logic [31:0] second,
                                                    input xtea_pkg::t_key_set key);
        logic [31:0]    v0;
        logic [31:0]    v1;
        logic [31:0]    sum;
        xtea_pkg::t_res blk;
        v0 = first;
        v1 = second;
        if (func == FUNC_ENC) begin
            sum = '0;
            for (int n = 0; n < N_ROUNDS; n++) begin
                v0 += feistel_mix(v1) ^ (sum + key[sum[1:0]]);
                sum += xtea_pkg::DELTA;
                v1 += feistel_mix(v0) ^ (sum + key[sum[12:11]]);
            end
        end else begin
            // start from the sum the encipher pass ends on
            sum = 32'(xtea_pkg::DELTA * N_ROUNDS);
            for (int n = 0; n < N_ROUNDS; n++) begin
                v1 -= feistel_mix(v0) ^ (sum + key[sum[12:11]]);
                sum -= xtea_pkg::DELTA;
                v0 -= feistel_mix(v1) ^ (sum + key[sum[1:0]]);
            end
        end
        blk.v0 = v0;
        blk.v1 = v1;
        return blk;
    endfunction

    // Random word, now and then a corner value
    function automatic logic [31:0] pick_word();
        if ($urandom_range(9) != 0)
            return $urandom();
        case ($urandom_range(4))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // Present one request, with random gaps ahead of it, and hold it until taken
    task automatic send_block(input logic func, input logic [31:0] first,
                              input logic [31:0] second);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= func;
        i_half_first  <= first;
        i_half_second <= second;
        do @(posedge i_clk); while (o_stall);
        pending_blocks.push_back(cipher_block(func, first, second, key_model));
    endtask

    // Drop valid and hold until every pending result has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_blocks.size() != 0);
    endtask

    task automatic write_key_word(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= t_paddr'(idx * REG_STRIDE);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        key_model[idx] = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Read one key word back and compare it with the programmed value
    task automatic check_key_word(input int idx);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= t_paddr'(idx * REG_STRIDE);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== key_model[idx]) begin
            $display("%0t ERROR key_word%0d readback: expected %08h actual %08h",
                     $time, idx, key_model[idx], got);
            fail_count++;
        end
        @(posedge i_clk);
    endtask

    // Drain the pipeline, load a new key and read it back
    task automatic set_key(input xtea_pkg::t_key_set key);
        wait_drained();
        for (int idx = 0; idx < xtea_pkg::KEY_WORDS; idx++)
            write_key_word(idx, key[idx]);
        for (int idx = 0; idx < xtea_pkg::KEY_WORDS; idx++)
            check_key_word(idx);
    endtask

    // Compare one accepted result with the oldest pending block
    task automatic check_block();
        xtea_pkg::t_res want;
        if (pending_blocks.size() == 0) begin
            $display("%0t ERROR unexpected result: expected none actual %08h %08h",
                     $time, o_out_first, o_out_second);
            fail_count++;
            return;
        end
        want = pending_blocks.pop_front();
        if (o_out_first !== want.v0) begin
            $display("%0t ERROR out_first: expected %08h actual %08h",
                     $time, want.v0, o_out_first);
            fail_count++;
        end
        if (o_out_second !== want.v1) begin
            $display("%0t ERROR out_second: expected %08h actual %08h",
                     $time, want.v1, o_out_second);
            fail_count++;
        end
    endtask

    // Take results and stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                check_block();
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Abort when no request or result moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ERROR watchdog: no handshake for %0d cycles",
                         $time, quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Key resets to zero; run corner blocks under it
    task automatic test_reset_key();
        send_gap_pct   = 35;
        recv_stall_pct = 67;
        for (int idx = 0; idx < xtea_pkg::KEY_WORDS; idx++)
            check_key_word(idx);
        send_block(FUNC_ENC, 32'h0000_0000, 32'h0000_0000);
        send_block(FUNC_DEC, 32'h0000_0000, 32'h0000_0000);
        send_block(FUNC_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(FUNC_DEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Corner keys and blocks, plus encipher/decipher round trips
    task automatic test_directed_blocks();
        xtea_pkg::t_res sealed;
        set_key({4{32'hFFFF_FFFF}});
        send_block(FUNC_ENC, 32'h8000_0000, 32'h7FFF_FFFF);
        send_block(FUNC_DEC, 32'h8000_0000, 32'h7FFF_FFFF);
        send_block(FUNC_ENC, 32'h0000_0001, 32'hFFFF_FFFE);
        send_block(FUNC_DEC, 32'h7FFF_FFFF, 32'h8000_0000);

        set_key({32'h7654_3210, 32'hFEDC_BA98, 32'h89AB_CDEF, 32'h0123_4567});
        sealed = cipher_block(FUNC_ENC, 32'h4142_4344, 32'h4546_4748, key_model);
        send_block(FUNC_ENC, 32'h4142_4344, 32'h4546_4748);
        send_block(FUNC_DEC, sealed.v0, sealed.v1);
        sealed = cipher_block(FUNC_DEC, 32'h0000_0000, 32'hFFFF_FFFF, key_model);
        send_block(FUNC_DEC, 32'h0000_0000, 32'hFFFF_FFFF);
        send_block(FUNC_ENC, sealed.v0, sealed.v1);

        // one hot, all-but-top-bit and zero words in the key slots
        set_key({32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0000});
        send_block(FUNC_ENC, 32'h1234_5678, 32'h9ABC_DEF0);
        send_block(FUNC_DEC, 32'h1234_5678, 32'h9ABC_DEF0);
    endtask

    // Random blocks under a run of random keys
    task automatic run_random_blocks(input bit pause_midway);
        xtea_pkg::t_res sealed;
        bit             have_sealed;
        logic           func;
        logic [31:0]    first;
        logic [31:0]    second;
        for (int k = 0; k < KEYS_PER_PHASE; k++) begin
            set_key({pick_word(), pick_word(), pick_word(), pick_word()});
            have_sealed = 1'b0;
            for (int n = 0; n < BLOCKS_PER_KEY; n++) begin
                if (pause_midway && k == KEYS_PER_PHASE / 2 && n == BLOCKS_PER_KEY / 2)
                    wait_drained();
                // now and then decipher a block enciphered earlier
                if (have_sealed && $urandom_range(99) < 25) begin
                    send_block(FUNC_DEC, sealed.v0, sealed.v1);
                end else begin
                    func   = 1'($urandom_range(1));
                    first  = pick_word();
                    second = pick_word();
                    if (func == FUNC_ENC) begin
                        sealed      = cipher_block(func, first, second, key_model);
                        have_sealed = 1'b1;
                    end
                    send_block(func, first, second);
                end
            end
        end
    endtask

    task automatic test_sender_gaps();
        send_gap_pct   = 35;
        recv_stall_pct = 67;
        run_random_blocks(1'b1);
    endtask

    task automatic test_receiver_stalls();
        send_gap_pct   = 67;
        recv_stall_pct = 35;
        run_random_blocks(1'b0);
    endtask

    task automatic test_full_rate();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        run_random_blocks(1'b0);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_key();
        test_directed_blocks();
        test_sender_gaps();
        test_receiver_stalls();
        test_full_rate();

        // hold off past the pipeline depth to catch stray results
        wait_drained();
        repeat (HOLD_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
